### src/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared sizes, opcodes, status codes and payload types of the two-stack deque.
// ----------------------------------------------------------------------------
`default_nettype none

package tsd_pkg;

	localparam int SIDE_DEPTH = 1024;
	localparam int ELEM_WIDTH = 32;

	localparam int OP_W     = 3;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = 11;
	localparam int COUNT_W  = 12;
	localparam int STATUS_W = 2;

	localparam int AW     = (SIDE_DEPTH > 1) ? $clog2(SIDE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(SIDE_DEPTH + 1);
	localparam int TOT_W  = CNT_W + 1;
	localparam int CMP_W  = (TOT_W > IDX_W) ? TOT_W : IDX_W;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_READ_INDEX = 3'd2;
	localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         index;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [STATUS_W-1:0]      status;
		logic [COUNT_W-1:0]       count;
		logic                     is_empty;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic emit;
	} tsd_cmd_t;

endpackage

`default_nettype wire

### src/two_stack_deque.sv
// ----------------------------------------------------------------------------
// two_stack_deque
// Double-ended store built from a front stack and a back stack, no pops.
// ----------------------------------------------------------------------------
// Latency: the result strobes on done in the cycle after start is taken.
// Requests: start is not taken while busy; busy covers the cycle in which the
//   registered memory read is presented.
// Reset: arst_n clears both fill counters and the sequencer; stack memories
//   are not cleared and are read only below their fill counts.
`default_nettype none

module two_stack_deque
	import tsd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	tsd_cmd_t cmd;

	tsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	tsd_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

### src/tsd_ctrl.sv
// ----------------------------------------------------------------------------
// tsd_ctrl
// Sequencer: takes a request, then presents its result for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_ctrl
	import tsd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output tsd_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RESP = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign busy     = (state_q == S_RESP);
	assign done     = (state_q == S_RESP);
	assign cmd.load = start && (state_q == S_IDLE);
	assign cmd.emit = (state_q == S_RESP);

`ifndef SYNTHESIS
	a_load_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.emit) else $error("request not answered next cycle");
	a_emit_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !cmd.emit) else $error("result shown twice");
	a_emit_has_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd.emit) |-> $past(cmd.load)) else $error("result without request");
`endif

endmodule

`default_nettype wire

### src/tsd_dpath.sv
// ----------------------------------------------------------------------------
// tsd_dpath
// Two stack memories, their fill counters, address mapping and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_dpath
	import tsd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire tsd_cmd_t cmd,
	input  wire req_t     req,
	output rsp_t          rsp
);

	localparam logic [1:0] SEL_NONE  = 2'd0;
	localparam logic [1:0] SEL_FRONT = 2'd1;
	localparam logic [1:0] SEL_BACK  = 2'd2;

	logic [ELEM_WIDTH-1:0] front_mem [0:SIDE_DEPTH-1];
	logic [ELEM_WIDTH-1:0] back_mem  [0:SIDE_DEPTH-1];

	logic [CNT_W-1:0]      front_cnt_q;
	logic [CNT_W-1:0]      back_cnt_q;
	logic [ELEM_WIDTH-1:0] front_rd_q;
	logic [ELEM_WIDTH-1:0] back_rd_q;
	logic [1:0]            sel_s1;
	logic [STATUS_W-1:0]   status_s1;

	logic [TOT_W-1:0]      total;
	logic [CMP_W-1:0]      idx_ext;
	logic [CMP_W-1:0]      front_ext;
	logic [CMP_W-1:0]      back_pos_ext;
	logic [CNT_W-1:0]      front_pos;
	logic                  front_full;
	logic                  back_full;
	logic                  front_we;
	logic                  back_we;
	logic                  front_re;
	logic                  back_re;
	logic [AW-1:0]         front_addr;
	logic [AW-1:0]         back_addr;
	logic [1:0]            sel_d;
	logic [STATUS_W-1:0]   status_d;
	logic [ELEM_WIDTH-1:0] wr_val;

	assign total        = TOT_W'(front_cnt_q) + TOT_W'(back_cnt_q);
	assign idx_ext      = CMP_W'(req.index);
	assign front_ext    = CMP_W'(front_cnt_q);
	assign back_pos_ext = idx_ext - front_ext;
	assign front_pos    = front_cnt_q - CNT_W'(1) - CNT_W'(req.index);
	assign front_full   = (front_cnt_q == CNT_W'(SIDE_DEPTH));
	assign back_full    = (back_cnt_q == CNT_W'(SIDE_DEPTH));
	assign wr_val       = ELEM_WIDTH'(req.value);

	always_comb begin
		front_we   = 1'b0;
		back_we    = 1'b0;
		front_re   = 1'b0;
		back_re    = 1'b0;
		front_addr = front_cnt_q[AW-1:0];
		back_addr  = back_cnt_q[AW-1:0];
		sel_d      = SEL_NONE;
		status_d   = ST_OK;
		case (req.op)
			OP_PUSH_FRONT: begin
				if (front_full) status_d = ST_FULL;
				else            front_we = 1'b1;
			end
			OP_PUSH_BACK: begin
				if (back_full) status_d = ST_FULL;
				else           back_we = 1'b1;
			end
			OP_READ_INDEX: begin
				if (idx_ext >= CMP_W'(total)) begin
					status_d = ST_RANGE;
				end else if (idx_ext < front_ext) begin
					front_re   = 1'b1;
					front_addr = front_pos[AW-1:0];
					sel_d      = SEL_FRONT;
				end else begin
					back_re   = 1'b1;
					back_addr = back_pos_ext[AW-1:0];
					sel_d     = SEL_BACK;
				end
			end
			OP_READ_FRONT: begin
				if (front_cnt_q != '0) begin
					front_re   = 1'b1;
					front_addr = AW'(front_cnt_q - CNT_W'(1));
					sel_d      = SEL_FRONT;
				end else if (back_cnt_q != '0) begin
					back_re   = 1'b1;
					back_addr = '0;
					sel_d     = SEL_BACK;
				end else begin
					status_d = ST_EMPTY;
				end
			end
			OP_READ_BACK: begin
				if (back_cnt_q != '0) begin
					back_re   = 1'b1;
					back_addr = AW'(back_cnt_q - CNT_W'(1));
					sel_d     = SEL_BACK;
				end else if (front_cnt_q != '0) begin
					front_re   = 1'b1;
					front_addr = '0;
					sel_d      = SEL_FRONT;
				end else begin
					status_d = ST_EMPTY;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load && front_we) front_mem[front_addr] <= wr_val;
		if (cmd.load && front_re) front_rd_q <= front_mem[front_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load && back_we) back_mem[back_addr] <= wr_val;
		if (cmd.load && back_re) back_rd_q <= back_mem[back_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_cnt_q <= '0;
			back_cnt_q  <= '0;
		end else if (cmd.load) begin
			if (front_we) front_cnt_q <= front_cnt_q + CNT_W'(1);
			if (back_we)  back_cnt_q  <= back_cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sel_s1    <= sel_d;
			status_s1 <= status_d;
		end
	end

	always_comb begin
		case (sel_s1)
			SEL_FRONT: rsp.data = DATA_W'(front_rd_q);
			SEL_BACK:  rsp.data = DATA_W'(back_rd_q);
			default:   rsp.data = '0;
		endcase
	end

	assign rsp.status   = status_s1;
	assign rsp.count    = COUNT_W'(total);
	assign rsp.is_empty = (total == '0);

`ifndef SYNTHESIS
	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_cnt_q <= CNT_W'(SIDE_DEPTH)) else $error("front count overflow");
	a_back_bound: assert property (@(posedge clk) disable iff (!arst_n)
		back_cnt_q <= CNT_W'(SIDE_DEPTH)) else $error("back count overflow");
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.load |=> $stable(front_cnt_q) && $stable(back_cnt_q))
		else $error("count moved without request");
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && (status_d == ST_FULL) |=> $stable(total))
		else $error("push on full stack changed count");
`endif

endmodule

`default_nettype wire
